### hw/rtl/dwmac_pkg.sv
package dwmac_pkg;

	localparam int CHANNELS   = 16;
	localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TAP  = 1'b1;

	localparam logic REG_CLAMP_LOW  = 1'b0;
	localparam logic REG_CLAMP_HIGH = 1'b1;

	localparam logic signed [7:0] CLAMP_LOW_RST  = -8'sd128;
	localparam logic signed [7:0] CLAMP_HIGH_RST = 8'sd127;

	localparam logic [31:0] HALF_LSB = 32'h8000_0000;

	typedef struct packed {
		logic [3:0]         channel;
		logic signed [31:0] acc;
		logic signed [31:0] bias;
		logic signed [31:0] scale;
	} rq_entry_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_LO,
		B_HI,
		B_FIN
	} back_state_t;

endpackage

### hw/rtl/depthwise_int8_mac_requant_core.sv
// Depthwise int8 tap accumulator with requantization over 16 channels. Load beats and
// taps that are not the last of a window are taken one per cycle while full is low and
// finish at once in the front (8x8 multiply and 32-bit accumulate per cycle). A last tap
// hands its sum, bias and scale to a two-entry queue; the requant unit behind it uses its
// single 32x32 multiplier twice, in states LO and HI (low and high part of the 41x32
// product), then rounds half to even and clamps; it takes a new entry only in IDLE. full
// follows the queue, so back-to-back windows are paced by the requant unit. A result sits
// in an output register until popped; FIN stalls while it is occupied and not popped.
module depthwise_int8_mac_requant_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               action,
	input  logic [3:0]         channel,
	input  logic signed [7:0]  src_value,
	input  logic signed [7:0]  weight_value,
	input  logic               last_tap,
	input  logic signed [31:0] bias_value,
	input  logic signed [31:0] scale_value,
	output logic               empty,
	input  logic               pop,
	output logic [3:0]         out_channel,
	output logic signed [7:0]  out_value,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data
);
	import dwmac_pkg::*;

	logic              accept;
	logic              rq_push;
	logic              rq_full;
	logic              rq_pop;
	logic              rq_empty;
	rq_entry_t         wr_entry;
	rq_entry_t         rd_entry;
	logic              out_valid;
	logic              fin_load;
	logic signed [7:0] clamp_low_q;
	logic signed [7:0] clamp_high_q;

	assign full   = rq_full;
	assign accept = push && !rq_full;
	assign empty  = !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_low_q  <= CLAMP_LOW_RST;
			clamp_high_q <= CLAMP_HIGH_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_CLAMP_LOW:  clamp_low_q  <= cfg_data;
				REG_CLAMP_HIGH: clamp_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	dwmac_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.action       (action),
		.channel      (channel),
		.src_value    (src_value),
		.weight_value (weight_value),
		.last_tap     (last_tap),
		.bias_value   (bias_value),
		.scale_value  (scale_value),
		.rq_push      (rq_push),
		.rq_entry     (wr_entry)
	);

	dwmac_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (rq_push),
		.wr_entry (wr_entry),
		.full     (rq_full),
		.pop      (rq_pop),
		.rd_entry (rd_entry),
		.empty    (rq_empty)
	);

	dwmac_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rq_entry    (rd_entry),
		.rq_empty    (rq_empty),
		.rq_pop      (rq_pop),
		.clamp_low   (clamp_low_q),
		.clamp_high  (clamp_high_q),
		.out_valid   (out_valid),
		.out_pop     (pop),
		.out_channel (out_channel),
		.out_value   (out_value),
		.fin_load    (fin_load)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		rq_push |-> !rq_full)
		else $error("queue written while full");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		rq_pop |-> !rq_empty)
		else $error("requant unit took from an empty queue");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(empty) |-> $past(fin_load))
		else $error("result appeared without a finished requant");

endmodule

### hw/rtl/dwmac_front.sv
module dwmac_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic                  action,
	input  logic [3:0]            channel,
	input  logic signed [7:0]     src_value,
	input  logic signed [7:0]     weight_value,
	input  logic                  last_tap,
	input  logic signed [31:0]    bias_value,
	input  logic signed [31:0]    scale_value,
	output logic                  rq_push,
	output dwmac_pkg::rq_entry_t  rq_entry
);
	import dwmac_pkg::*;

	logic [31:0]         acc_q   [CHANNELS];
	logic [31:0]         bias_q  [CHANNELS];
	logic [31:0]         scale_q [CHANNELS];
	logic [CH_IDX_W-1:0] idx;
	logic                in_range;
	logic signed [15:0]  prod;
	logic [31:0]         sum;
	logic                do_load;
	logic                do_tap;

	assign idx      = CH_IDX_W'(channel);
	assign in_range = ({28'd0, channel} < 32'(CHANNELS));
	assign prod     = 16'(src_value) * 16'(weight_value);
	assign sum      = acc_q[idx] + {{16{prod[15]}}, prod};
	assign do_load  = accept && in_range && (action == ACT_LOAD);
	assign do_tap   = accept && in_range && (action == ACT_TAP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				acc_q[i] <= '0;
			end
		end else if (do_tap) begin
			acc_q[idx] <= last_tap ? '0 : sum;
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			bias_q[idx]  <= bias_value;
			scale_q[idx] <= scale_value;
		end
	end

	assign rq_push          = do_tap && last_tap;
	assign rq_entry.channel = channel;
	assign rq_entry.acc     = sum;
	assign rq_entry.bias    = bias_q[idx];
	assign rq_entry.scale   = scale_q[idx];

endmodule

### hw/rtl/dwmac_fifo.sv
module dwmac_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  dwmac_pkg::rq_entry_t  wr_entry,
	output logic                  full,
	input  logic                  pop,
	output dwmac_pkg::rq_entry_t  rd_entry,
	output logic                  empty
);
	import dwmac_pkg::*;

	rq_entry_t             mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full     = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

### hw/rtl/dwmac_back.sv
module dwmac_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dwmac_pkg::rq_entry_t  rq_entry,
	input  logic                  rq_empty,
	output logic                  rq_pop,
	input  logic signed [7:0]     clamp_low,
	input  logic signed [7:0]     clamp_high,
	output logic                  out_valid,
	input  logic                  out_pop,
	output logic [3:0]            out_channel,
	output logic signed [7:0]     out_value,
	output logic                  fin_load
);
	import dwmac_pkg::*;

	back_state_t        state_q;
	back_state_t        state_d;

	logic [3:0]         ch_q;
	logic               neg_q;
	logic [40:0]        mt_q;
	logic [31:0]        mc_q;
	logic [63:0]        lo_q;
	logic [41:0]        q_q;
	logic [31:0]        r_q;
	logic               out_valid_q;

	logic signed [41:0] t;
	logic [41:0]        t_mag;
	logic [31:0]        mul_a;
	logic [63:0]        mul_p;
	logic               rnd;
	logic [42:0]        q_rnd;
	logic signed [43:0] y;
	logic signed [43:0] lo_ext;
	logic signed [43:0] hi_ext;
	logic signed [43:0] y_lo;
	logic signed [7:0]  y_cl;
	logic               slot_free;

	// t = acc * 256 + bias, then magnitudes for the unsigned product
	assign t     = {{2{rq_entry.acc[31]}}, rq_entry.acc, 8'd0}
	             + {{10{rq_entry.bias[31]}}, rq_entry.bias};
	assign t_mag = t[41] ? (42'd0 - t) : t;

	assign mul_a = (state_q == B_LO) ? mt_q[31:0] : {23'd0, mt_q[40:32]};
	assign mul_p = 64'(mul_a) * 64'(mc_q);

	assign rnd    = (r_q > HALF_LSB) || ((r_q == HALF_LSB) && q_q[0]);
	assign q_rnd  = {1'b0, q_q} + {42'd0, rnd};
	assign y      = neg_q ? (44'sd0 - $signed({1'b0, q_rnd})) : $signed({1'b0, q_rnd});
	assign lo_ext = {{36{clamp_low[7]}}, clamp_low};
	assign hi_ext = {{36{clamp_high[7]}}, clamp_high};
	assign y_lo   = (y < lo_ext) ? lo_ext : y;
	assign y_cl   = (y_lo > hi_ext) ? clamp_high : y_lo[7:0];

	assign slot_free = !out_valid_q || out_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		rq_pop   = 1'b0;
		fin_load = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!rq_empty) begin
					rq_pop  = 1'b1;
					state_d = B_LO;
				end
			end
			B_LO: begin
				state_d = B_HI;
			end
			B_HI: begin
				state_d = B_FIN;
			end
			B_FIN: begin
				if (slot_free) begin
					fin_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rq_pop) begin
			ch_q  <= rq_entry.channel;
			neg_q <= t[41] ^ rq_entry.scale[31];
			mt_q  <= t_mag[40:0];
			mc_q  <= rq_entry.scale[31] ? (32'd0 - rq_entry.scale) : rq_entry.scale;
		end
		if (state_q == B_LO) begin
			lo_q <= mul_p;
		end
		if (state_q == B_HI) begin
			q_q <= mul_p[41:0] + {10'd0, lo_q[63:32]};
			r_q <= lo_q[31:0];
		end
		if (fin_load) begin
			out_channel <= ch_q;
			out_value   <= y_cl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (out_pop) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### bench/depthwise_int8_mac_requant_core_tb.sv
module depthwise_int8_mac_requant_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dwmac_pkg::*;

	typedef struct {
		logic               action;
		logic [3:0]         channel;
		logic signed [7:0]  src;
		logic signed [7:0]  weight;
		logic               last;
		logic signed [31:0] bias;
		logic signed [31:0] scale;
	} beat_t;

	typedef struct {
		logic [3:0]        channel;
		logic signed [7:0] value;
	} lane_out_t;

	localparam int MAX_SHOWN       = 10;
	localparam int DRAIN_CYCLES    = 16;
	localparam int RANDOM_PHASES   = 6;
	localparam int BEATS_PER_PHASE = 192;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic               action = ACT_LOAD;
	logic [3:0]         channel = '0;
	logic signed [7:0]  src_value = '0;
	logic signed [7:0]  weight_value = '0;
	logic               last_tap = 1'b0;
	logic signed [31:0] bias_value = '0;
	logic signed [31:0] scale_value = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic [3:0]         out_channel;
	logic signed [7:0]  out_value;
	logic               cfg_write = 1'b0;
	logic               cfg_index = REG_CLAMP_LOW;
	logic [7:0]         cfg_data = '0;

	lane_out_t          pending_outs[$];
	logic signed [31:0] lane_acc [CHANNELS] = '{default: '0};
	logic signed [31:0] lane_bias [CHANNELS] = '{default: '0};
	logic signed [31:0] lane_scale [CHANNELS] = '{default: '0};
	logic signed [7:0]  clamp_lo_m = CLAMP_LOW_RST;
	logic signed [7:0]  clamp_hi_m = CLAMP_HIGH_RST;

	int send_idle_pct = 0;
	int pop_stall_pct = 0;
	int beats_sent = 0;
	int results_seen = 0;
	int mismatch_count = 0;

	depthwise_int8_mac_requant_core dut (.*);

	always #6 clk = ~clk;

	function automatic logic signed [7:0] requantize(input logic signed [31:0] acc,
			input logic signed [31:0] bias, input logic signed [31:0] scale);
		logic signed [63:0] t, s, y;
		logic [63:0]        mt, mc, q;
		logic [95:0]        prod;
		logic               neg;
		t = acc * 64'sd256 + bias;
		s = scale;
		neg = (t < 0) != (s < 0);
		mt = (t < 0) ? -t : t;
		mc = (s < 0) ? -s : s;
		prod = mt * mc;
		q = prod[95:32];
		if (prod[31:0] > HALF_LSB || (prod[31:0] == HALF_LSB && q[0]))
			q = q + 1;
		y = neg ? -$signed(q) : $signed(q);
		if (y < clamp_lo_m)
			y = clamp_lo_m;
		if (y > clamp_hi_m)
			y = clamp_hi_m;
		return y[7:0];
	endfunction

	task automatic predict_beat(input beat_t b);
		lane_out_t o;
		if (int'(b.channel) < CHANNELS) begin
			if (b.action == ACT_LOAD) begin
				lane_bias[b.channel] = b.bias;
				lane_scale[b.channel] = b.scale;
			end else begin
				lane_acc[b.channel] = lane_acc[b.channel] + b.src * b.weight;
				if (b.last) begin
					o.channel = b.channel;
					o.value = requantize(lane_acc[b.channel], lane_bias[b.channel],
						lane_scale[b.channel]);
					pending_outs.push_back(o);
					lane_acc[b.channel] = '0;
				end
			end
		end
	endtask

	task automatic send_beat(input beat_t b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push         <= 1'b1;
		action       <= b.action;
		channel      <= b.channel;
		src_value    <= b.src;
		weight_value <= b.weight;
		last_tap     <= b.last;
		bias_value   <= b.bias;
		scale_value  <= b.scale;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_beat(b);
		beats_sent++;
	endtask

	task automatic drain_outputs();
		@(negedge clk);
		push <= 1'b0;
		while (pending_outs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_clamp(input logic signed [7:0] lo, input logic signed [7:0] hi);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_CLAMP_LOW;
		cfg_data  <= lo;
		@(posedge clk);
		clamp_lo_m = lo;
		@(negedge clk);
		cfg_index <= REG_CLAMP_HIGH;
		cfg_data  <= hi;
		@(posedge clk);
		clamp_hi_m = hi;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic logic signed [31:0] pick_bias();
		case ($urandom_range(7))
			0, 1, 2, 3: pick_bias = 32'($urandom_range(2097152)) - 32'd1048576;
			4, 5: pick_bias = $urandom;
			6: pick_bias = 32'sh7FFF_FFFF;
			default: pick_bias = 32'sh8000_0000;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_scale();
		logic signed [31:0] m;
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: begin
				m = $urandom_range(32768, 2048);
				pick_scale = $urandom_range(1) ? -m : m;
			end
			6, 7: pick_scale = $urandom;
			8: pick_scale = '0;
			default: pick_scale = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
		endcase
	endfunction

	// fields a beat does not use carry junk
	function automatic beat_t tap_beat(input logic [3:0] ch, input logic signed [7:0] s,
			input logic signed [7:0] w, input logic last);
		beat_t b;
		b.action = ACT_TAP;
		b.channel = ch;
		b.src = s;
		b.weight = w;
		b.last = last;
		b.bias = $urandom;
		b.scale = $urandom;
		return b;
	endfunction

	function automatic beat_t load_beat(input logic [3:0] ch, input logic signed [31:0] bias,
			input logic signed [31:0] scale);
		beat_t b;
		b.action = ACT_LOAD;
		b.channel = ch;
		b.src = 8'($urandom);
		b.weight = 8'($urandom);
		b.last = 1'($urandom_range(1));
		b.bias = bias;
		b.scale = scale;
		return b;
	endfunction

	function automatic beat_t noise_beat();
		beat_t b;
		b.action = 1'($urandom_range(1));
		b.channel = 4'($urandom);
		b.src = 8'($urandom);
		b.weight = 8'($urandom);
		b.last = 1'($urandom_range(1));
		b.bias = $urandom;
		b.scale = $urandom;
		return b;
	endfunction

	task automatic test_lane_loads();
		logic signed [31:0] tie_bias [4] = '{32'sd2, 32'sd6, -32'sd6, 32'sd10};
		for (int ch = 0; ch < CHANNELS; ch++) begin
			case (ch)
				0: send_beat(load_beat(4'(ch), 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
				1: send_beat(load_beat(4'(ch), 32'sh8000_0000, 32'sh7FFF_FFFF));
				2, 3, 4, 5: send_beat(load_beat(4'(ch), tie_bias[ch - 2], 32'sh4000_0000));
				7: send_beat(load_beat(4'(ch), pick_bias(), 32'sh8000_0000));
				default: send_beat(load_beat(4'(ch), pick_bias(), pick_scale()));
			endcase
		end
	endtask

	task automatic test_saturation();
		send_beat(tap_beat(4'd0, 8'sd127, 8'sd127, 1'b1));
		send_beat(tap_beat(4'd1, -8'sd128, 8'sd127, 1'b1));
		send_beat(tap_beat(4'd7, -8'sd128, -8'sd128, 1'b1));
	endtask

	// scale of one quarter on biases of 2 mod 4 lands exactly on .5
	task automatic test_round_half_even();
		for (int ch = 2; ch < 6; ch++)
			send_beat(tap_beat(4'(ch), 8'sd0, 8'($urandom), 1'b1));
	endtask

	task automatic test_accumulator_clear();
		send_beat(tap_beat(4'd6, 8'sd3, 8'sd5, 1'b0));
		send_beat(tap_beat(4'd6, -8'sd7, 8'sd9, 1'b1));
		send_beat(tap_beat(4'd6, 8'sd2, 8'sd2, 1'b1));
	endtask

	task automatic test_random_phases();
		int                idle_tab [RANDOM_PHASES] = '{0, 49, 0, 25, 0, 25};
		int                stall_tab [RANDOM_PHASES] = '{0, 0, 49, 25, 0, 25};
		logic signed [7:0] lo_tab [RANDOM_PHASES] = '{-128, -20, 127, -128, 127, 0};
		logic signed [7:0] hi_tab [RANDOM_PHASES] = '{127, 35, -128, -128, 127, 0};
		int                start;
		int                n;
		logic [3:0]        ch;
		lo_tab[RANDOM_PHASES - 1] = 8'($urandom);
		hi_tab[RANDOM_PHASES - 1] = 8'($urandom);
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			send_idle_pct = idle_tab[p];
			pop_stall_pct = stall_tab[p];
			set_clamp(lo_tab[p], hi_tab[p]);
			start = beats_sent;
			while (beats_sent - start < BEATS_PER_PHASE) begin
				case ($urandom_range(19))
					0, 1: send_beat(load_beat(4'($urandom), pick_bias(), pick_scale()));
					2, 3, 4, 5: send_beat(noise_beat());
					default: begin
						ch = 4'($urandom);
						n = $urandom_range(9, 1);
						for (int i = 0; i < n; i++)
							send_beat(tap_beat(ch, 8'($urandom), 8'($urandom), i == n - 1));
					end
				endcase
			end
			drain_outputs();
		end
	endtask

	always @(negedge clk)
		pop <= ($urandom_range(99) >= pop_stall_pct);

	always @(posedge clk) begin : check_beat
		lane_out_t want;
		if (arst_n && pop && !empty) begin
			results_seen++;
			if (pending_outs.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_SHOWN)
					$display("unexpected result beat: lane %0d value %0d", out_channel, out_value);
			end else begin
				want = pending_outs.pop_front();
				if (out_channel !== want.channel || out_value !== want.value) begin
					mismatch_count++;
					if (mismatch_count <= MAX_SHOWN)
						$display("mismatch: expected lane %0d value %0d, got lane %0d value %0d",
							want.channel, want.value, out_channel, out_value);
				end
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		set_clamp(CLAMP_LOW_RST, CLAMP_HIGH_RST);
		test_lane_loads();
		test_saturation();
		test_round_half_even();
		test_accumulator_clear();
		drain_outputs();
		test_random_phases();
		$display("%0d input beats, %0d results checked, %0d mismatches",
			beats_sent, results_seen, mismatch_count);
		$display("covered extremes, half-even ties, clears, %0d clamp/stall phases",
			RANDOM_PHASES);
		if (mismatch_count == 0)
			$display("depthwise_int8_mac_requant_core regression: pass");
		else
			$display("depthwise_int8_mac_requant_core regression: fail");
		$finish;
	end

	// normal run is well under 1 ms
	initial begin
		#20ms;
		$display("timeout");
		$display("depthwise_int8_mac_requant_core regression: fail");
		$finish;
	end

endmodule
